@@ design/tfdc_pkg.sv @@
// shared types, widths and rounding helpers for the tangent frame detail codec
// no dependencies; imported by tfdc_unitize, tangent_frame_detail_codec and the testbench
package tfdc_pkg;

  localparam int CoordW = 16;
  localparam int InW = CoordW + 4;
  localparam int UnitW = 32;
  localparam int UnitBits = 30;
  localparam int SqrtStages = 16;
  localparam int DivStages = 16;
  localparam int AccW = 66;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [InW-1:0] raw_t;
  typedef logic signed [UnitW-1:0] unit_t;

  typedef struct packed {
    logic   mode;
    coord_t edge_x;
    coord_t edge_y;
    coord_t edge_z;
    coord_t normal_x;
    coord_t normal_y;
    coord_t normal_z;
    coord_t vec_x;
    coord_t vec_y;
    coord_t vec_z;
  } item_in_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   frame_valid;
  } item_out_t;

  // data riding alongside an item through a normalize unit
  typedef struct packed {
    logic              mode;
    logic              ok;
    coord_t [2:0]      e;
    coord_t [2:0]      v;
    unit_t [2:0]       n;
  } sb_t;

  localparam logic signed [AccW-1:0] SatHi = AccW'((2 ** (CoordW - 1)) - 1);
  localparam logic signed [AccW-1:0] SatLo = -SatHi - AccW'(1);

  // shift right by UnitBits, rounded half away from zero
  function automatic logic signed [AccW-1:0] rnd30(input logic signed [AccW-1:0] x);
    logic [AccW-1:0] mag;
    logic [AccW-1:0] m;
    mag = x[AccW-1] ? AccW'(-x) : AccW'(x);
    m = (mag + (AccW'(1) << (UnitBits - 1))) >> UnitBits;
    return x[AccW-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic coord_t sat_coord(input logic signed [AccW-1:0] x);
    logic signed [AccW-1:0] c;
    c = x;
    if (x > SatHi) begin
      c = SatHi;
    end else if (x < SatLo) begin
      c = SatLo;
    end
    return coord_t'(c[CoordW-1:0]);
  endfunction

endpackage

@@ design/tfdc_unitize.sv @@
// pipelined vector normalize: scale to [2^30, 2^31), square sum, isqrt, divide
// depends on tfdc_pkg; two pipeline steps of isqrt and of division per stage
module tfdc_unitize (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  tfdc_pkg::raw_t [2:0]   vec_i,
  input  tfdc_pkg::sb_t          sb_i,
  output logic                   valid_o,
  output tfdc_pkg::unit_t [2:0]  unit_o,
  output logic                   nz_o,
  output tfdc_pkg::sb_t          sb_o
);
  import tfdc_pkg::*;

  typedef struct packed {
    logic       nz;
    logic [2:0] neg;
    sb_t        sb;
  } ctl_t;

  // stage 1: magnitudes and maximum
  logic                  v1_q;
  ctl_t                  c1_q;
  logic [2:0][InW-1:0]   a1_q;
  logic [InW-1:0]        m1_q;
  logic [2:0][InW-1:0]   a_d;
  logic [InW-1:0]        m_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_d[i] = vec_i[i][InW-1] ? InW'(-vec_i[i]) : InW'(vec_i[i]);
    end
    m_d = a_d[0];
    if (a_d[1] > m_d) m_d = a_d[1];
    if (a_d[2] > m_d) m_d = a_d[2];
  end

  // stage 2: shift amount from the leading one
  logic                  v2_q;
  ctl_t                  c2_q;
  logic [2:0][InW-1:0]   a2_q;
  logic [4:0]            k2_q;
  logic [4:0]            msb_d;

  always_comb begin
    msb_d = '0;
    for (int b = 0; b < InW; b++) begin
      if (m1_q[b]) msb_d = 5'(b);
    end
  end

  // stage 3: scaled magnitudes
  logic                  v3_q;
  ctl_t                  c3_q;
  logic [2:0][30:0]      w3_q;

  // stage 4: squares
  logic                  v4_q;
  ctl_t                  c4_q;
  logic [2:0][30:0]      w4_q;
  logic [2:0][61:0]      p4_q;

  // isqrt pipe, index 0 holds the sum of squares
  logic                  sv_q [SqrtStages+1];
  ctl_t                  sc_q [SqrtStages+1];
  logic [2:0][30:0]      sw_q [SqrtStages+1];
  logic [63:0]           sx_q [SqrtStages+1];
  logic [63:0]           sr_q [SqrtStages+1];

  // divide pipe, index 0 holds the prepared dividends
  logic                  dv_q [DivStages+1];
  ctl_t                  dc_q [DivStages+1];
  logic [2:0][33:0]      drem_q [DivStages+1];
  logic [2:0][31:0]      dlow_q [DivStages+1];
  logic [2:0][31:0]      dquo_q [DivStages+1];
  logic [31:0]           ds_q [DivStages+1];

  logic                  vo_q;
  ctl_t                  co_q;
  unit_t [2:0]           uo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      sv_q[0] <= 1'b0;
      dv_q[0] <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      sv_q[0] <= v4_q;
      dv_q[0] <= sv_q[SqrtStages];
      vo_q <= dv_q[DivStages];
    end
  end

  logic [63:0] ndiv_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ndiv_d[i] = (64'(sw_q[SqrtStages][i]) << UnitBits) + 64'(sr_q[SqrtStages][31:1]);
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q.sb <= sb_i;
    c1_q.nz <= 1'b0;
    for (int i = 0; i < 3; i++) begin
      c1_q.neg[i] <= vec_i[i][InW-1];
    end
    a1_q <= a_d;
    m1_q <= m_d;

    c2_q <= '{nz: |m1_q, neg: c1_q.neg, sb: c1_q.sb};
    a2_q <= a1_q;
    k2_q <= 5'(UnitBits) - msb_d;

    c3_q <= c2_q;
    for (int i = 0; i < 3; i++) begin
      w3_q[i] <= 31'(a2_q[i]) << k2_q;
    end

    c4_q <= c3_q;
    w4_q <= w3_q;
    for (int i = 0; i < 3; i++) begin
      p4_q[i] <= w3_q[i] * w3_q[i];
    end

    sc_q[0] <= c4_q;
    sw_q[0] <= w4_q;
    sx_q[0] <= 64'(p4_q[0]) + 64'(p4_q[1]) + 64'(p4_q[2]);
    sr_q[0] <= '0;

    dc_q[0] <= sc_q[SqrtStages];
    ds_q[0] <= sr_q[SqrtStages][31:0];
    for (int i = 0; i < 3; i++) begin
      drem_q[0][i] <= 34'(ndiv_d[i][63:32]);
      dlow_q[0][i] <= ndiv_d[i][31:0];
      dquo_q[0][i] <= '0;
    end

    co_q <= dc_q[DivStages];
    for (int i = 0; i < 3; i++) begin
      uo_q[i] <= dc_q[DivStages].neg[i] ? -$signed(dquo_q[DivStages][i])
                                         : $signed(dquo_q[DivStages][i]);
    end
  end

  for (genvar j = 0; j < SqrtStages; j++) begin : g_sqrt
    logic [63:0] x_d;
    logic [63:0] r_d;
    logic [63:0] bit_d;

    always_comb begin
      x_d = sx_q[j];
      r_d = sr_q[j];
      bit_d = '0;
      for (int t = 0; t < 2; t++) begin
        bit_d = 64'd1 << (2 * (31 - 2 * j - t));
        if (x_d >= r_d + bit_d) begin
          x_d = x_d - (r_d + bit_d);
          r_d = (r_d >> 1) + bit_d;
        end else begin
          r_d = r_d >> 1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j+1] <= 1'b0;
      end else begin
        sv_q[j+1] <= sv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      sc_q[j+1] <= sc_q[j];
      sw_q[j+1] <= sw_q[j];
      sx_q[j+1] <= x_d;
      sr_q[j+1] <= r_d;
    end
  end

  for (genvar j = 0; j < DivStages; j++) begin : g_div
    logic [2:0][33:0] rem_d;
    logic [2:0][31:0] low_d;
    logic [2:0][31:0] quo_d;

    always_comb begin
      rem_d = drem_q[j];
      low_d = dlow_q[j];
      quo_d = dquo_q[j];
      for (int i = 0; i < 3; i++) begin
        for (int t = 0; t < 2; t++) begin
          rem_d[i] = {rem_d[i][32:0], low_d[i][31]};
          low_d[i] = low_d[i] << 1;
          if (rem_d[i] >= 34'(ds_q[j])) begin
            rem_d[i] = rem_d[i] - 34'(ds_q[j]);
            quo_d[i] = {quo_d[i][30:0], 1'b1};
          end else begin
            quo_d[i] = {quo_d[i][30:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      dc_q[j+1] <= dc_q[j];
      ds_q[j+1] <= ds_q[j];
      drem_q[j+1] <= rem_d;
      dlow_q[j+1] <= low_d;
      dquo_q[j+1] <= quo_d;
    end
  end

  assign valid_o = vo_q;
  assign unit_o = uo_q;
  assign nz_o = co_q.nz;
  assign sb_o = co_q.sb;

endmodule

@@ design/tangent_frame_detail_codec.sv @@
// top level: unit normal, gram-schmidt tangent, binormal, encode or decode
// depends on tfdc_pkg and tfdc_unitize (two instances)
//
//   port       dir  width          meaning
//   start      in   1              item offered; taken when busy is low
//   busy       out  1              always low, an item can be taken every cycle
//   item_i     in   item_in_t      mode, edge, normal, vector
//   done_o     out  1              result strobe, one cycle per item
//   result_o   out  item_out_t     out_x/y/z, frame_valid
//
// one item per clock; the path from the taking edge to the result strobe runs through
// the input register, two normalize units of 39 register stages each (with their isqrt
// and divide pipes) and the projection and cross product stages.
// reset clears only the valid bits of the pipeline.
// the receiver cannot stall, so nothing ever holds the pipeline.
module tangent_frame_detail_codec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  tfdc_pkg::item_in_t  item_i,
  output logic                done_o,
  output tfdc_pkg::item_out_t result_o
);
  import tfdc_pkg::*;

  // input register
  logic         iv_q;
  sb_t          isb_q;
  raw_t [2:0]   inr_q;

  // normal normalize
  logic         av;
  unit_t [2:0]  an;
  logic         anz;
  sb_t          asb;

  // gram-schmidt stages
  logic                     g1v_q, g2v_q, g3v_q, g4v_q;
  sb_t                      g1sb_q, g2sb_q, g3sb_q, g4sb_q;
  logic signed [2:0][47:0]  g1p_q;
  raw_t                     g2d_q;
  logic signed [2:0][51:0]  g3p_q;
  raw_t [2:0]               g4t_q;

  // tangent normalize
  logic         bv;
  unit_t [2:0]  bt;
  logic         bnz;
  sb_t          bsb;

  // cross product and output stages
  logic                     x1v_q, x2v_q, m1v_q, ov_q;
  sb_t                      x1sb_q, x2sb_q;
  logic                     m1ok_q;
  unit_t [2:0]              x1t_q, x2t_q;
  logic signed [5:0][63:0]  x1p_q;
  unit_t [2:0]              x2b_q;
  logic signed [8:0][47:0]  m1p_q;
  item_out_t                res_q;

  logic accept;
  assign accept = start & ~busy;
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
      g1v_q <= 1'b0;
      g2v_q <= 1'b0;
      g3v_q <= 1'b0;
      g4v_q <= 1'b0;
      x1v_q <= 1'b0;
      x2v_q <= 1'b0;
      m1v_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      iv_q <= accept;
      g1v_q <= av;
      g2v_q <= g1v_q;
      g3v_q <= g2v_q;
      g4v_q <= g3v_q;
      x1v_q <= bv;
      x2v_q <= x1v_q;
      m1v_q <= x2v_q;
      ov_q <= m1v_q;
    end
  end

  tfdc_unitize u_norm_n (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (iv_q),
    .vec_i   (inr_q),
    .sb_i    (isb_q),
    .valid_o (av),
    .unit_o  (an),
    .nz_o    (anz),
    .sb_o    (asb)
  );

  tfdc_unitize u_norm_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (g4v_q),
    .vec_i   (g4t_q),
    .sb_i    (g4sb_q),
    .valid_o (bv),
    .unit_o  (bt),
    .nz_o    (bnz),
    .sb_o    (bsb)
  );

  // frame rows for the output products
  unit_t [2:0][2:0] frm;
  logic signed [2:0][AccW-1:0] sum_d;

  always_comb begin
    frm[0] = x2sb_q.n;
    frm[1] = x2t_q;
    frm[2] = x2b_q;
    for (int i = 0; i < 3; i++) begin
      sum_d[i] = AccW'($signed(m1p_q[3*i])) + AccW'($signed(m1p_q[3*i+1]))
                 + AccW'($signed(m1p_q[3*i+2]));
    end
  end

  always_ff @(posedge clk_i) begin
    isb_q.mode <= item_i.mode;
    isb_q.ok <= 1'b0;
    isb_q.e <= {item_i.edge_z, item_i.edge_y, item_i.edge_x};
    isb_q.v <= {item_i.vec_z, item_i.vec_y, item_i.vec_x};
    isb_q.n <= '0;
    inr_q[0] <= InW'(item_i.normal_x);
    inr_q[1] <= InW'(item_i.normal_y);
    inr_q[2] <= InW'(item_i.normal_z);

    // d = rnd(e . n)
    g1sb_q <= '{mode: asb.mode, ok: anz, e: asb.e, v: asb.v, n: an};
    for (int i = 0; i < 3; i++) begin
      g1p_q[i] <= $signed(asb.e[i]) * $signed(an[i]);
    end

    g2sb_q <= g1sb_q;
    g2d_q <= InW'(rnd30(AccW'($signed(g1p_q[0])) + AccW'($signed(g1p_q[1]))
                        + AccW'($signed(g1p_q[2]))));

    g3sb_q <= g2sb_q;
    for (int i = 0; i < 3; i++) begin
      g3p_q[i] <= $signed(g2sb_q.n[i]) * g2d_q;
    end

    // tangent residual e - rnd(n * d)
    g4sb_q <= g3sb_q;
    for (int i = 0; i < 3; i++) begin
      g4t_q[i] <= InW'(AccW'($signed(g3sb_q.e[i])) - rnd30(AccW'($signed(g3p_q[i]))));
    end

    // binormal n x t
    x1sb_q <= '{mode: bsb.mode, ok: bsb.ok & bnz, e: bsb.e, v: bsb.v, n: bsb.n};
    x1t_q <= bt;
    x1p_q[0] <= $signed(bsb.n[1]) * $signed(bt[2]);
    x1p_q[1] <= $signed(bsb.n[2]) * $signed(bt[1]);
    x1p_q[2] <= $signed(bsb.n[2]) * $signed(bt[0]);
    x1p_q[3] <= $signed(bsb.n[0]) * $signed(bt[2]);
    x1p_q[4] <= $signed(bsb.n[0]) * $signed(bt[1]);
    x1p_q[5] <= $signed(bsb.n[1]) * $signed(bt[0]);

    x2sb_q <= x1sb_q;
    x2t_q <= x1t_q;
    for (int i = 0; i < 3; i++) begin
      x2b_q[i] <= UnitW'(rnd30(AccW'($signed(x1p_q[2*i])) - AccW'($signed(x1p_q[2*i+1]))));
    end

    // encode takes frame rows, decode takes frame columns
    m1ok_q <= x2sb_q.ok;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m1p_q[3*i+j] <= (x2sb_q.mode ? $signed(frm[j][i]) : $signed(frm[i][j]))
                        * $signed(x2sb_q.v[j]);
      end
    end

    res_q.frame_valid <= m1ok_q;
    res_q.out_x <= m1ok_q ? sat_coord(rnd30(sum_d[0])) : '0;
    res_q.out_y <= m1ok_q ? sat_coord(rnd30(sum_d[1])) : '0;
    res_q.out_z <= m1ok_q ? sat_coord(rnd30(sum_d[2])) : '0;
  end

  assign done_o = ov_q;
  assign result_o = res_q;

endmodule

@@ bench/tangent_frame_detail_codec_tb.sv @@
// testbench for tangent_frame_detail_codec: directed and random vertices in both modes,
// checked against an in-bench fixed-point frame predictor; depends on tfdc_pkg
`timescale 1ns / 1ps

module tangent_frame_detail_codec_tb;
  import tfdc_pkg::*;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;
  localparam int QBits = 30;
  localparam int StallLimit = 5000;
  localparam int DrainCycles = 150;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  item_in_t item_i = '0;
  logic done_o;
  item_out_t result_o;

  item_out_t expected_q[$];
  int errors = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;
  logic accepted;

  tangent_frame_detail_codec DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .done_o(done_o), .result_o(result_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint unsigned magof(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // shift right by 30, half away from zero
  function automatic longint rshr(longint v);
    longint unsigned m;
    m = (magof(v) + (64'd1 << (QBits - 1))) >> QBits;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned peak(longint w0, longint w1, longint w2);
    longint unsigned m;
    m = magof(w0);
    if (magof(w1) > m) m = magof(w1);
    if (magof(w2) > m) m = magof(w2);
    return m;
  endfunction

  // unit vector in Q1.30 after power-of-two scaling; 0 if the vector is zero
  function automatic bit to_unit(input longint a0, a1, a2, output longint u0, u1, u2);
    longint w[3];
    longint unsigned m, ss, s, q;
    w[0] = a0; w[1] = a1; w[2] = a2;
    u0 = 0; u1 = 0; u2 = 0;
    m = peak(w[0], w[1], w[2]);
    if (m == 0) return 1'b0;
    while (m >= (64'd1 << 31)) begin
      for (int i = 0; i < 3; i++) w[i] = w[i] >>> 1;
      m = peak(w[0], w[1], w[2]);
    end
    while (m < (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) w[i] = w[i] * 2;
      m = peak(w[0], w[1], w[2]);
    end
    ss = 0;
    for (int i = 0; i < 3; i++) ss = ss + magof(w[i]) * magof(w[i]);
    s = int_sqrt(ss);
    for (int i = 0; i < 3; i++) begin
      q = ((magof(w[i]) << QBits) + s / 2) / s;
      w[i] = w[i] < 0 ? -longint'(q) : longint'(q);
    end
    u0 = w[0]; u1 = w[1]; u2 = w[2];
    return 1'b1;
  endfunction

  function automatic coord_t clamp16(longint v);
    if (v > 32767) return coord_t'(16'sd32767);
    if (v < -32768) return coord_t'(-16'sd32768);
    return coord_t'(v);
  endfunction

  function automatic item_out_t frame_result(item_in_t it);
    item_out_t o;
    longint e[3], v[3], n[3], t[3], tr[3], b[3], r[3];
    longint d;
    o = '0;
    e[0] = it.edge_x; e[1] = it.edge_y; e[2] = it.edge_z;
    v[0] = it.vec_x; v[1] = it.vec_y; v[2] = it.vec_z;
    if (!to_unit(it.normal_x, it.normal_y, it.normal_z, n[0], n[1], n[2])) return o;
    d = rshr(e[0] * n[0] + e[1] * n[1] + e[2] * n[2]);
    for (int i = 0; i < 3; i++) tr[i] = e[i] - rshr(n[i] * d);
    if (!to_unit(tr[0], tr[1], tr[2], t[0], t[1], t[2])) return o;
    b[0] = rshr(n[1] * t[2] - n[2] * t[1]);
    b[1] = rshr(n[2] * t[0] - n[0] * t[2]);
    b[2] = rshr(n[0] * t[1] - n[1] * t[0]);
    if (it.mode == ModeEncode) begin
      r[0] = rshr(n[0] * v[0] + n[1] * v[1] + n[2] * v[2]);
      r[1] = rshr(t[0] * v[0] + t[1] * v[1] + t[2] * v[2]);
      r[2] = rshr(b[0] * v[0] + b[1] * v[1] + b[2] * v[2]);
    end else begin
      for (int i = 0; i < 3; i++) r[i] = rshr(n[i] * v[0] + t[i] * v[1] + b[i] * v[2]);
    end
    o.out_x = clamp16(r[0]);
    o.out_y = clamp16(r[1]);
    o.out_z = clamp16(r[2]);
    o.frame_valid = 1'b1;
    return o;
  endfunction

  // start stays high after the taking edge so the next item can follow at once
  task automatic send_vertex(item_in_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    item_i = it;
    do @(posedge clk_i); while (busy);
    expected_q.push_back(frame_result(it));
  endtask

  function automatic item_in_t vertex(logic m, coord_t ex, ey, ez, nx, ny, nz,
                                      coord_t vx, vy, vz);
    item_in_t it;
    it.mode = m;
    it.edge_x = ex; it.edge_y = ey; it.edge_z = ez;
    it.normal_x = nx; it.normal_y = ny; it.normal_z = nz;
    it.vec_x = vx; it.vec_y = vy; it.vec_z = vz;
    return it;
  endfunction

  task automatic test_directed();
    coord_t mx, mn;
    mx = 16'sh7fff;
    mn = -16'sh8000;
    for (int m = 0; m < 2; m++) begin
      send_vertex(vertex(m[0], mx, mx, mx, mx, mx, mx, mx, mx, mx));
      send_vertex(vertex(m[0], mn, mn, mn, mn, mn, mn, mn, mn, mn));
      send_vertex(vertex(m[0], 0, 4096, 0, 4096, 0, 0, mx, mx, mx));
      send_vertex(vertex(m[0], mn, 0, 0, 0, 0, mx, mn, mn, mn));
      // zero normal
      send_vertex(vertex(m[0], 4096, 0, 0, 0, 0, 0, 100, 200, 300));
      // no neighbour
      send_vertex(vertex(m[0], 0, 0, 0, 0, 0, 4096, 100, 200, 300));
      // edge parallel to normal, gram-schmidt leaves nothing
      send_vertex(vertex(m[0], 0, 0, 8192, 0, 0, 4096, 100, 200, 300));
      send_vertex(vertex(m[0], 1, 0, 0, 0, 1, 0, 1, mn, mx));
      send_vertex(vertex(m[0], mx, mn, 1, -1, mx, mn, mx, mn, -1));
      send_vertex(vertex(m[0], 16'sh5555, -16'sh2aab, 3, 7, -9, 16'sh1234, 16'sh5a5a,
                         -16'sh5a5b, 16'sh0f0f));
    end
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom_range(65535));
      1: return coord_t'($signed($urandom_range(512)) - 256);
      2: return coord_t'($signed($urandom_range(8192)) - 4096);
      default: return $urandom_range(1) ? coord_t'(16'sh7fff) : coord_t'(-16'sh8000);
    endcase
  endfunction

  task automatic test_random(int count, int pct);
    item_in_t it;
    int k;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      it = vertex(1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord());
      k = $urandom_range(99);
      if (k < 4) begin
        it.normal_x = 0; it.normal_y = 0; it.normal_z = 0;
      end else if (k < 8) begin
        it.edge_x = 0; it.edge_y = 0; it.edge_z = 0;
      end else if (k < 12) begin
        it.normal_x = coord_t'($signed($urandom_range(200)) - 100);
        it.normal_y = coord_t'($signed($urandom_range(200)) - 100);
        it.normal_z = coord_t'($signed($urandom_range(200)) - 100);
        it.edge_x = coord_t'(it.normal_x * 3); it.edge_y = coord_t'(it.normal_y * 3);
        it.edge_z = coord_t'(it.normal_z * 3);
      end else if (k < 18) begin
        it.normal_x = 0; it.normal_y = 0;
      end
      send_vertex(it);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %p", result_o);
        errors++;
      end else begin
        item_out_t x;
        x = expected_q.pop_front();
        if (result_o.out_x !== x.out_x) begin
          $error("out_x expected %0d actual %0d", x.out_x, result_o.out_x);
          errors++;
        end
        if (result_o.out_y !== x.out_y) begin
          $error("out_y expected %0d actual %0d", x.out_y, result_o.out_y);
          errors++;
        end
        if (result_o.out_z !== x.out_z) begin
          $error("out_z expected %0d actual %0d", x.out_z, result_o.out_z);
          errors++;
        end
        if (result_o.frame_valid !== x.frame_valid) begin
          $error("frame_valid expected %0b actual %0b", x.frame_valid,
                 result_o.frame_valid);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no item taken and no result
  always @(posedge clk_i) begin
    accepted = start && !busy;
    if (!rst_ni || accepted || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tangent_frame_detail_codec_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(640, 27);
    test_random(640, 64);
    test_random(650, 0);
    @(negedge clk_i);
    start = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tangent_frame_detail_codec_tb: PASS");
    end else begin
      $display("tangent_frame_detail_codec_tb: FAIL");
    end
    $finish;
  end

endmodule
